[rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define CHK_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("check failed: lbl");

// property checked on every clock edge, reset included
`define CHK_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("check failed: lbl");

`endif

[rtl/pocol_pkg.sv]
// shared constants and types of the pixel overlap collision test
package pocol_pkg;

  // command codes of an input word
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_DRAW  = 2'd1;
  localparam logic [1:0] CMD_TEST  = 2'd2;

  // configuration register indexes
  localparam logic REG_AREA_WIDTH  = 1'b0;
  localparam logic REG_AREA_HEIGHT = 1'b1;

  // reset values of the area registers
  localparam logic [8:0] AREA_WIDTH_RST  = 9'd256;
  localparam logic [8:0] AREA_HEIGHT_RST = 9'd256;

  // default map dimensions
  localparam int AREA_MAX_WIDTH_DEF  = 256;
  localparam int AREA_MAX_HEIGHT_DEF = 256;

  // map port control from the pipeline
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_bit;
  } map_ctrl_t;

endpackage

[rtl/pocol_addr.sv]
// area clipping and cell index stage
module pocol_addr #(
  parameter int AREA_MAX_WIDTH  = 256,
  parameter int AREA_MAX_HEIGHT = 256,
  parameter int ADDR_W          = 16
) (
  input  logic              clk,
  input  logic              en,
  input  logic [8:0]        col,
  input  logic [8:0]        row,
  input  logic [8:0]        area_width,
  input  logic [8:0]        area_height,
  output logic [ADDR_W-1:0] idx,
  output logic              in_area
);
  import pocol_pkg::*;

  localparam int W_LIM = (AREA_MAX_WIDTH < 511) ? AREA_MAX_WIDTH : 511;
  localparam int H_LIM = (AREA_MAX_HEIGHT < 511) ? AREA_MAX_HEIGHT : 511;

  logic [8:0]  w_eff;
  logic [8:0]  h_eff;
  logic [17:0] prod;
  logic [18:0] sum;

  // effective area: zero taken as one, saturate at the map size
  always_comb begin
    if (area_width == 9'd0) begin
      w_eff = 9'd1;
    end else if (32'(area_width) > W_LIM) begin
      w_eff = 9'(W_LIM);
    end else begin
      w_eff = area_width;
    end
    if (area_height == 9'd0) begin
      h_eff = 9'd1;
    end else if (32'(area_height) > H_LIM) begin
      h_eff = 9'(H_LIM);
    end else begin
      h_eff = area_height;
    end
  end

  // row-major cell index with the current stride
  assign prod = 18'(row) * 18'(w_eff);
  assign sum  = 19'(prod) + 19'(col);

  always_ff @(posedge clk) begin
    if (en) begin
      idx     <= ADDR_W'(sum);
      in_area <= (col < w_eff) && (row < h_eff);
    end
  end

endmodule

[rtl/pocol_map.sv]
// one-bit occupancy map with clearing sweep
module pocol_map #(
  parameter int CELLS = 65536
) (
  input  logic                        clk,
  input  logic                        rst,
  input  pocol_pkg::map_ctrl_t        ctrl,
  input  logic [$clog2(CELLS)-1:0]    addr,
  input  logic                        sweep_start,
  output logic                        rd_bit,
  output logic                        busy
);
  import pocol_pkg::*;

  localparam int ADDR_W = $clog2(CELLS);

  logic              mem [CELLS];
  logic              sweep;
  logic [ADDR_W-1:0] sweep_addr;

  // sweep control, runs after reset and on request
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep      <= 1'b1;
      sweep_addr <= '0;
    end else if (sweep_start) begin
      sweep      <= 1'b1;
      sweep_addr <= '0;
    end else if (sweep) begin
      if (sweep_addr == ADDR_W'(CELLS - 1)) begin
        sweep <= 1'b0;
      end
      sweep_addr <= sweep_addr + 1'b1;
    end
  end

  // single write port: sweep or pipeline write
  always_ff @(posedge clk) begin
    if (sweep) begin
      mem[sweep_addr] <= 1'b0;
    end else if (ctrl.wr_en) begin
      mem[addr] <= ctrl.wr_bit;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_bit <= mem[addr];
    end
  end

  assign busy = sweep;

endmodule

[rtl/pixel_overlap_collision_test_core.sv]
// Pixel overlap collision test: last test words pass s1 to s3 into the result register.
// Draw and test words go through at one per cycle unless stalled; one map access each
// in the memory stage. A clear word waits for the words in s1 to s3 to drain, then
// sweeps the map one cell per cycle, all AREA_MAX_WIDTH * AREA_MAX_HEIGHT cells (65536
// by default), input stalled meanwhile. Reset (synchronous, active high) lowers both flags,
// sets the area to 256 x 256 and starts the sweep; a held result stalls the whole pipeline.
module pixel_overlap_collision_test_core #(
  parameter int AREA_MAX_WIDTH  = pocol_pkg::AREA_MAX_WIDTH_DEF,
  parameter int AREA_MAX_HEIGHT = pocol_pkg::AREA_MAX_HEIGHT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] command,
  input  logic [7:0] pos_x,
  input  logic [7:0] pos_y,
  input  logic [7:0] pixel_col,
  input  logic [7:0] pixel_row,
  input  logic [7:0] pixel_value,
  input  logic       last_pixel,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       collided,
  output logic       clipped
);
  import pocol_pkg::*;

  localparam int CELLS  = AREA_MAX_WIDTH * AREA_MAX_HEIGHT;
  localparam int ADDR_W = $clog2(CELLS);

  logic [8:0]        area_width;
  logic [8:0]        area_height;
  logic              hit_flag;
  logic              clip_flag;
  logic              clear_pend;

  logic              advance;
  logic              accept;
  logic              sweep_start;
  logic              map_busy;
  logic              rd_bit;
  map_ctrl_t         map_ctrl;

  logic              s1_valid;
  logic [1:0]        s1_cmd;
  logic [8:0]        s1_col;
  logic [8:0]        s1_row;
  logic              s1_solid;
  logic              s1_last;

  logic              s2_valid;
  logic [1:0]        s2_cmd;
  logic              s2_solid;
  logic              s2_last;
  logic [ADDR_W-1:0] s2_idx;
  logic              s2_inside;

  logic              s3_valid;
  logic              s3_test;
  logic              s3_inside;
  logic              s3_solid;
  logic              s3_last;
  logic              s3_hit;

  // handshake and pipeline movement
  assign advance     = !(out_valid && out_stall);
  assign in_stall    = map_busy || clear_pend || !advance;
  assign accept      = in_valid && !in_stall;
  assign sweep_start = clear_pend && !s1_valid && !s2_valid && !s3_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      area_width  <= AREA_WIDTH_RST;
      area_height <= AREA_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_AREA_WIDTH:  area_width  <= cfg_data;
        REG_AREA_HEIGHT: area_height <= cfg_data;
        default:         area_width  <= area_width;
      endcase
    end
  end

  // clear request waits for the pipeline to drain
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_pend <= 1'b0;
    end else if (accept && command == CMD_CLEAR) begin
      clear_pend <= 1'b1;
    end else if (sweep_start) begin
      clear_pend <= 1'b0;
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept && command != CMD_CLEAR;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_cmd    <= command;
      s1_col    <= 9'(pos_x) + 9'(pixel_col);
      s1_row    <= 9'(pos_y) + 9'(pixel_row);
      s1_solid  <= pixel_value != 8'd0;
      s1_last   <= last_pixel;
      s2_cmd    <= s1_cmd;
      s2_solid  <= s1_solid;
      s2_last   <= s1_last;
      s3_test   <= s2_cmd == CMD_TEST;
      s3_inside <= s2_inside;
      s3_solid  <= s2_solid;
      s3_last   <= s2_last;
    end
  end

  // cell index stage
  pocol_addr #(
    .AREA_MAX_WIDTH  (AREA_MAX_WIDTH),
    .AREA_MAX_HEIGHT (AREA_MAX_HEIGHT),
    .ADDR_W          (ADDR_W)
  ) u_addr (
    .clk         (clk),
    .en          (advance),
    .col         (s1_col),
    .row         (s1_row),
    .area_width  (area_width),
    .area_height (area_height),
    .idx         (s2_idx),
    .in_area     (s2_inside)
  );

  // map access: draw writes, every stage move reads
  always_comb begin
    map_ctrl.rd_en  = advance;
    map_ctrl.wr_en  = advance && s2_valid && s2_cmd == CMD_DRAW && s2_inside;
    map_ctrl.wr_bit = s2_solid;
  end

  pocol_map #(
    .CELLS (CELLS)
  ) u_map (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (map_ctrl),
    .addr        (s2_idx),
    .sweep_start (sweep_start),
    .rd_bit      (rd_bit),
    .busy        (map_busy)
  );

  // solid test pixel over an occupied cell
  assign s3_hit = s3_valid && s3_test && s3_inside && s3_solid && rd_bit;

  // sticky flags
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_flag  <= 1'b0;
      clip_flag <= 1'b0;
    end else if (sweep_start) begin
      hit_flag  <= 1'b0;
      clip_flag <= 1'b0;
    end else if (advance) begin
      if (s3_hit) begin
        hit_flag <= 1'b1;
      end
      if (s2_valid && (s2_cmd == CMD_DRAW || s2_cmd == CMD_TEST) && !s2_inside) begin
        clip_flag <= 1'b1;
      end
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s3_valid && s3_test && s3_last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      collided <= hit_flag || s3_hit;
      clipped  <= clip_flag;
    end
  end

endmodule

[rtl/pocol_checker.sv]
// port-level checks of the collision test core and their binding
`include "assert_macros.svh"

module pocol_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] command,
  input logic       out_valid,
  input logic       out_stall,
  input logic       collided,
  input logic       clipped
);
  import pocol_pkg::*;

  // a held result word keeps its value
  `CHK_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(collided) && $stable(clipped))

  // a clear word blocks the next input word
  `CHK_ASSERT(a_clear_stalls, clk, rst, in_valid && !in_stall && command == CMD_CLEAR |=> in_stall)

  // reset starts the map sweep, so input is stalled
  `CHK_ASSERT_ALWAYS(a_reset_sweeps, clk, rst |=> in_stall)

  // a held result stalls the input side
  `CHK_ASSERT(a_stall_when_held, clk, rst, out_valid && out_stall |-> in_stall)

endmodule

bind pixel_overlap_collision_test_core pocol_checker u_pocol_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .command   (command),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .collided  (collided),
  .clipped   (clipped)
);

[bench/pixel_overlap_collision_test_core_tb.sv]
// self-checking testbench of the pixel overlap collision test core
`timescale 1ns / 100ps

module pixel_overlap_collision_test_core_tb;
  import pocol_pkg::*;

  localparam int MAX_W     = AREA_MAX_WIDTH_DEF;
  localparam int MAX_H     = AREA_MAX_HEIGHT_DEF;
  localparam int MAP_CELLS = MAX_W * MAX_H;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // one input word as the bench sees it
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] px;
    logic [7:0] py;
    logic [7:0] pcol;
    logic [7:0] prow;
    logic [7:0] pval;
    logic       last;
  } pix_word_t;

  // one result word
  typedef struct packed {
    logic collided;
    logic clipped;
  } flags_t;

  // directed row: word plus an optional hand-written result
  typedef struct {
    pix_word_t w;
    bit        typed;
    flags_t    want;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_index = REG_AREA_WIDTH;
  logic [8:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] command = CMD_CLEAR;
  logic [7:0] pos_x = '0;
  logic [7:0] pos_y = '0;
  logic [7:0] pixel_col = '0;
  logic [7:0] pixel_row = '0;
  logic [7:0] pixel_value = '0;
  logic       last_pixel = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       collided;
  logic       clipped;

  // bench copy of the block state
  bit         occ_map [MAP_CELLS];
  bit         hit_q = 1'b0;
  bit         clip_q = 1'b0;
  logic [8:0] width_q = AREA_WIDTH_RST;
  logic [8:0] height_q = AREA_HEIGHT_RST;

  flags_t     pending_flags [$];
  int         fail_count = 0;
  int         send_pct = 0;
  int         recv_pct = 0;
  int         results_sent = 0;
  int         clears_left = 4;

  // directed table, area at its reset size of 256 x 256
  dir_row_t dir_rows [18] = '{
    '{'{CMD_TEST,   8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 1'b1}, 1'b1, '{1'b0, 1'b0}},
    '{'{CMD_DRAW,   8'd255, 8'd255, 8'd0,   8'd0,   8'd1,   1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{CMD_TEST,   8'd0,   8'd0,   8'd255, 8'd255, 8'd128, 1'b1}, 1'b1, '{1'b1, 1'b0}},
    '{'{CMD_DRAW,   8'd255, 8'd0,   8'd1,   8'd0,   8'd255, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{CMD_TEST,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b1}, 1'b1, '{1'b1, 1'b1}},
    '{'{CMD_CLEAR,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b1}, 1'b0, '{1'b0, 1'b0}},
    '{'{CMD_TEST,   8'd255, 8'd255, 8'd0,   8'd0,   8'd255, 1'b1}, 1'b1, '{1'b0, 1'b0}},
    '{'{CMD_DRAW,   8'd10,  8'd20,  8'd3,   8'd4,   8'd7,   1'b1}, 1'b0, '{1'b0, 1'b0}},
    '{'{CMD_DRAW,   8'd10,  8'd20,  8'd3,   8'd4,   8'd0,   1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{CMD_TEST,   8'd13,  8'd24,  8'd0,   8'd0,   8'd9,   1'b1}, 1'b1, '{1'b0, 1'b0}},
    '{'{CMD_DRAW,   8'd100, 8'd50,  8'd5,   8'd5,   8'd255, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{CMD_TEST,   8'd105, 8'd55,  8'd0,   8'd0,   8'd0,   1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{CMD_TEST,   8'd0,   8'd0,   8'd105, 8'd55,  8'd0,   1'b1}, 1'b1, '{1'b0, 1'b0}},
    '{'{CMD_UNUSED, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1}, 1'b0, '{1'b0, 1'b0}},
    '{'{CMD_TEST,   8'd100, 8'd50,  8'd5,   8'd5,   8'd1,   1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{CMD_TEST,   8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1}, 1'b1, '{1'b1, 1'b1}},
    '{'{CMD_DRAW,   8'd0,   8'd255, 8'd0,   8'd1,   8'd170, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{CMD_TEST,   8'd85,  8'd170, 8'd170, 8'd85,  8'd85,  1'b1}, 1'b0, '{1'b0, 1'b0}}
  };

  pixel_overlap_collision_test_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pixel_col  (pixel_col),
    .pixel_row  (pixel_row),
    .pixel_value(pixel_value),
    .last_pixel (last_pixel),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .collided   (collided),
    .clipped    (clipped)
  );

  always #5 clk = ~clk;

  // area register as the block uses it: zero means one, saturate at the map size
  function automatic int eff_dim(input logic [8:0] v, input int maxv);
    if (v == 0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  // apply one accepted word to the bench state and work out its result word
  function automatic void predict_overlap(input pix_word_t w, output bit has,
                                          output flags_t f);
    int  col;
    int  row;
    int  wd;
    int  ht;
    bit  in_area;
    has = 1'b0;
    wd = eff_dim(width_q, MAX_W);
    ht = eff_dim(height_q, MAX_H);
    col = int'(w.px) + int'(w.pcol);
    row = int'(w.py) + int'(w.prow);
    in_area = (col < wd) && (row < ht);
    case (w.cmd)
      CMD_CLEAR: begin
        foreach (occ_map[i]) occ_map[i] = 1'b0;
        hit_q = 1'b0;
        clip_q = 1'b0;
      end
      CMD_DRAW: begin
        if (in_area) occ_map[row * wd + col] = (w.pval != 0);
        else clip_q = 1'b1;
      end
      CMD_TEST: begin
        if (!in_area) clip_q = 1'b1;
        else if (w.pval != 0 && occ_map[row * wd + col]) hit_q = 1'b1;
        has = w.last;
      end
      default: ;
    endcase
    f.collided = hit_q;
    f.clipped = clip_q;
  endfunction

  // present one word, wait for it to be taken, queue its result
  task automatic send_word(input pix_word_t w, input bit typed, input flags_t want);
    bit     has;
    flags_t f;
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= w.cmd;
    pos_x <= w.px;
    pos_y <= w.py;
    pixel_col <= w.pcol;
    pixel_row <= w.prow;
    pixel_value <= w.pval;
    last_pixel <= w.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_overlap(w, has, f);
    if (has) begin
      pending_flags.push_back(typed ? want : f);
      results_sent++;
    end
    @(negedge clk);
  endtask

  // wait for every result, then let the pipeline settle
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_flags.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [8:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    if (idx == REG_AREA_WIDTH) width_q = val;
    else height_q = val;
  endtask

  // place a sprite pixel, either as corner plus offset or folded into the offset
  function automatic pix_word_t place(input logic [1:0] cmd, input int ox, input int oy,
                                      input int c, input int r, input bit fold);
    pix_word_t w;
    w = '0;
    w.cmd = cmd;
    if (fold) begin
      w.pcol = 8'(ox + c);
      w.prow = 8'(oy + r);
    end else begin
      w.px = 8'(ox);
      w.py = 8'(oy);
      w.pcol = 8'(c);
      w.prow = 8'(r);
    end
    return w;
  endfunction

  // random phase: mostly draw-then-test sprite pairs, some noise and clears
  task automatic run_phase(input int quota, input logic [8:0] w_set,
                           input logic [8:0] h_set, input bit clear_first);
    int        n_items;
    int        start_results;
    int        ox;
    int        oy;
    int        tx;
    int        ty;
    int        sw;
    int        sh;
    int        pick;
    bit        fold;
    pix_word_t w;
    n_items = 0;
    start_results = results_sent;
    cfg_write(REG_AREA_WIDTH, w_set);
    cfg_write(REG_AREA_HEIGHT, h_set);
    cfg_wr_en <= 1'b0;
    if (clear_first) begin
      w = '0;
      w.cmd = CMD_CLEAR;
      send_word(w, 1'b0, '0);
    end
    while (n_items < quota || results_sent - start_results < 10) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // noise word, any field value
        w = pix_word_t'($urandom);
        w.cmd = 2'($urandom);
        w.px = 8'($urandom);
        w.py = 8'($urandom);
        if (w.cmd == CMD_CLEAR) begin
          if (clears_left == 0) w.cmd = CMD_TEST;
          else clears_left--;
        end
        send_word(w, 1'b0, '0);
        if (w.cmd != CMD_UNUSED) n_items++;
      end else if (pick < 13 && clears_left > 0) begin
        clears_left--;
        w = '0;
        w.cmd = CMD_CLEAR;
        w.last = 1'($urandom_range(0, 1));
        send_word(w, 1'b0, '0);
        n_items++;
      end else begin
        // first sprite drawn, second sprite tested close by
        ox = $urandom_range(0, eff_dim(w_set, MAX_W) - 1);
        oy = $urandom_range(0, eff_dim(h_set, MAX_H) - 1);
        if ($urandom_range(0, 9) == 0) ox = $urandom_range(0, 255);
        if ($urandom_range(0, 9) == 0) oy = $urandom_range(0, 255);
        sw = $urandom_range(1, 4);
        sh = $urandom_range(1, 4);
        fold = ($urandom_range(0, 3) == 0) && (ox + sw <= 256) && (oy + sh <= 256);
        for (int r = 0; r < sh; r++) begin
          for (int c = 0; c < sw; c++) begin
            w = place(CMD_DRAW, ox, oy, c, r, fold);
            w.pval = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 255));
            w.last = ($urandom_range(0, 7) == 0);
            send_word(w, 1'b0, '0);
            n_items++;
          end
        end
        tx = ox + $urandom_range(0, 4) - 2;
        ty = oy + $urandom_range(0, 4) - 2;
        tx = (tx < 0) ? 0 : (tx > 255) ? 255 : tx;
        ty = (ty < 0) ? 0 : (ty > 255) ? 255 : ty;
        fold = fold && (tx + sw <= 256) && (ty + sh <= 256);
        for (int r = 0; r < sh; r++) begin
          for (int c = 0; c < sw; c++) begin
            w = place(CMD_TEST, tx, ty, c, r, fold);
            w.pval = $urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom_range(1, 255));
            w.last = (r == sh - 1 && c == sw - 1) || ($urandom_range(0, 5) == 0);
            send_word(w, 1'b0, '0);
            n_items++;
          end
        end
      end
    end
    drain();
  endtask

  // receiver stalls at the rate of the current phase
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_pct);
  end

  // compare each result word with the oldest one pending
  always @(posedge clk) begin : result_check
    flags_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_flags.size() == 0) begin
        $error("result word with nothing pending: collided %0b clipped %0b",
               collided, clipped);
        fail_count++;
      end else begin
        want = pending_flags.pop_front();
        if (collided !== want.collided) begin
          $error("collided: expected %0b, got %0b", want.collided, collided);
          fail_count++;
        end
        if (clipped !== want.clipped) begin
          $error("clipped: expected %0b, got %0b", want.clipped, clipped);
          fail_count++;
        end
      end
    end
  end

  // main sequence
  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    send_pct = 30;
    recv_pct = 77;
    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);
    drain();
    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0: begin
          send_pct = 30;
          recv_pct = 77;
        end
        1: begin
          send_pct = 77;
          recv_pct = 30;
        end
        default: begin
          send_pct = 0;
          recv_pct = 0;
        end
      endcase
      // area settings, extremes and a change of size without a clear among them
      case (p)
        0: run_phase(90, 9'd16, 9'd12, 1'b1);
        1: run_phase(90, 9'd0, 9'd511, 1'b0);
        2: run_phase(90, 9'd511, 9'd0, 1'b1);
        3: run_phase(90, 9'd1, 9'd1, 1'b0);
        4: run_phase(90, 9'd256, 9'd256, 1'b1);
        default: run_phase(90, 9'd300, 9'd40, 1'b0);
      endcase
    end
    if (fail_count == 0) begin
      $display("** pixel_overlap_collision_test_core: PASSED **");
    end else begin
      $display("** pixel_overlap_collision_test_core: FAILED **");
    end
    $finish;
  end

  // run limit, well above the slowest correct run with its map sweeps
  initial begin
    #50_000_000;
    $display("** pixel_overlap_collision_test_core: FAILED **");
    $finish;
  end

endmodule
